// ----- rtl/core/sdspi_pkg.sv -----
// shared types, constants and crc helpers for the spi-mode sd command engine
// no dependencies; imported by sd_spi_command_transaction, sd_txn_check_pkg and the test
`default_nettype none

package sdspi_pkg;

    // largest data block passed through, longer requests are clipped
    localparam int MAX_BLOCK_BYTES = 512;

    localparam int LEN_W   = 10;   // data_length field width
    localparam int POLL_W  = 20;   // poll counter and limit width
    localparam int TRIES_W = 8;

    // command frame: five bytes held plus the crc7 byte
    localparam int FRAME_HELD  = 5;
    localparam int FRAME_BYTES = 6;
    localparam int CRC_CNT_W   = 3;

    localparam logic [7:0] BYTE_FILL  = 8'hFF;
    localparam logic [7:0] BYTE_TOKEN = 8'hFE;
    localparam logic [7:0] CMD_START  = 8'h40;
    localparam logic [5:0] CMD_STOP   = 6'd12;

    localparam logic [6:0] CRC7_POLY = 7'h09;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CRC_VERIFY     = 2'd0,
        CFG_READY_LIMIT    = 2'd1,
        CFG_TOKEN_LIMIT    = 2'd2,
        CFG_RESPONSE_TRIES = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_READY    = 3'd1,
        ST_NO_RESPONSE  = 3'd2,
        ST_BAD_TOKEN    = 3'd3,
        ST_CRC_MISMATCH = 3'd4,
        ST_REJECTED     = 3'd5
    } t_status;

    typedef enum logic {
        CMD_TRANSACTION = 1'b0,
        CMD_BYTE        = 1'b1
    } t_command;

    typedef struct packed {
        logic       rejected;
        logic [7:0] response;
        t_status    status;
        logic       done;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       busy;
        logic [7:0] tx_byte;
    } t_result;

    // crc7 (x^7 + x^3 + 1) advanced by one byte, msb first
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
        logic [6:0] c;
        logic       fb;
        c = crc_in;
        for (int k = 7; k >= 0; k--) begin
            fb = c[6] ^ b[k];
            c  = {c[5:0], 1'b0};
            if (fb) begin
                c = c ^ CRC7_POLY;
            end
        end
        return c;
    endfunction

    // crc16-ccitt advanced by one byte, table-free form
    function automatic logic [15:0] crc16_byte(input logic [15:0] rv, input logic [7:0] b);
        logic [7:0] t;
        t = rv[15:8] ^ b;
        t = t ^ {4'h0, t[7:4]};
        return {rv[7:0], 8'h00} ^ {t[3:0], 12'h000} ^ {3'b000, t, 5'b00000} ^ {8'h00, t};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sd_spi_command_transaction.sv -----
// spi-mode sd command transaction engine at byte-exchange level
// depends on sdspi_pkg for types, constants and crc helpers
`default_nettype none

// One input beat is either a start (tuser 0: command index, argument, data
// length) or the report of one byte exchanged with the card (tuser 1: rx_byte).
// Every accepted beat produces exactly one result beat telling the host which
// byte to send next, whether another transfer is wanted, any data block byte
// and, at the end, the completion status and R1 response. The engine takes one
// beat per clock while the skid register is empty: the result is computed in the
// same cycle from the beat and the transaction state and is registered in the
// output register, or in a second skid register while the output is held, so
// the input side takes one more beat after the output stalls. The crc7 of the
// command frame is built by a small byte-per-cycle unit after a start, well
// before the crc7 byte is needed. Configuration writes are taken at any
// time (ready is tied high) and should be made while no transaction runs.
module sd_spi_command_transaction
    import sdspi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input beats
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [5:0] cmd_index, [37:6] cmd_argument, [47:38] data_length, [55:48] rx_byte
    input  wire logic [55:0] i_s_axis_tdata,
    // [0] command
    input  wire logic        i_s_axis_tuser,
    // result beats
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] tx_byte, [8] busy_res, [16:9] data_byte, [17] done_res,
    // [20:18] status, [28:21] response, [29] rejected, [31:30] zero
    output logic [31:0]      o_m_axis_tdata,
    // [0] data_valid
    output logic             o_m_axis_tuser,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_DUMMY, PH_READY, PH_FRAME, PH_STUFF,
        PH_R1, PH_TOKEN, PH_DATA, PH_CRCHI, PH_CRCLO
    } t_phase;

    // configuration
    logic                r_crc_verify;
    logic [POLL_W-1:0]   r_ready_limit;
    logic [POLL_W-1:0]   r_token_limit;
    logic [TRIES_W-1:0]  r_response_tries;

    // transaction state
    t_phase              r_phase,      n_phase;
    logic [LEN_W-1:0]    r_byte_count, n_byte_count;
    logic [POLL_W-1:0]   r_poll_count, n_poll_count;
    logic [15:0]         r_crc16,      n_crc16;
    logic [7:0]          r_crc_hi,     n_crc_hi;
    logic [7:0]          r_r1,         n_r1;
    logic                r_stop,       n_stop;
    logic [LEN_W-1:0]    r_block_len,  n_block_len;

    // frame bytes and crc7 unit
    logic [7:0]          r_frame [FRAME_HELD];
    logic [6:0]          r_crc7;
    logic [CRC_CNT_W-1:0] r_crc_cnt;

    // output register and skid stage
    logic                r_out_vld, r_skid_vld;
    t_result             r_out, r_skid, n_res;

    // input fields
    t_command            in_cmd;
    logic [5:0]          in_index;
    logic [31:0]         in_arg;
    logic [LEN_W-1:0]    in_len;
    logic [7:0]          in_rx;

    logic                s_accept, m_take, load_start;
    logic [POLL_W-1:0]   poll_inc;
    logic [LEN_W-1:0]    count_inc;
    logic [15:0]         crc16_next;
    logic [2:0]          frame_sel;
    logic [7:0]          frame_byte;

    assign in_cmd   = t_command'(i_s_axis_tuser);
    assign in_index = i_s_axis_tdata[5:0];
    assign in_arg   = i_s_axis_tdata[37:6];
    assign in_len   = i_s_axis_tdata[47:38];
    assign in_rx    = i_s_axis_tdata[55:48];

    assign o_s_axis_tready = !r_skid_vld;
    assign o_cfg_ready     = 1'b1;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign m_take          = r_out_vld && i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.data_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.rejected, r_out.response, r_out.status,
                              r_out.done, r_out.data_byte, r_out.busy, r_out.tx_byte};

    assign poll_inc   = r_poll_count + 1'b1;
    assign count_inc  = r_byte_count + 1'b1;
    assign crc16_next = crc16_byte(r_crc16, in_rx);

    // frame byte picked by the count: in the frame phase the next byte to send
    // is at index byte_count, on a rejected start the pending one at count - 1,
    // and the first byte when the card turns ready
    assign frame_sel = (in_cmd == CMD_TRANSACTION) ? (r_byte_count[2:0] - 3'd1) :
                       (r_phase == PH_READY)       ? 3'd0 : r_byte_count[2:0];

    always_comb begin
        frame_byte = BYTE_FILL;
        case (frame_sel)
            3'd0, 3'd1, 3'd2, 3'd3, 3'd4: frame_byte = r_frame[frame_sel];
            3'd5:                         frame_byte = {r_crc7, 1'b1};
            default:                      frame_byte = BYTE_FILL;
        endcase
    end

    // one step of the transaction per accepted beat
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_poll_count = r_poll_count;
        n_crc16      = r_crc16;
        n_crc_hi     = r_crc_hi;
        n_r1         = r_r1;
        n_stop       = r_stop;
        n_block_len  = r_block_len;
        load_start   = 1'b0;

        n_res            = '0;
        n_res.tx_byte    = BYTE_FILL;
        n_res.busy       = 1'b1;
        n_res.status     = ST_OK;

        if (in_cmd == CMD_TRANSACTION) begin
            if (r_phase != PH_IDLE) begin
                n_res.rejected = 1'b1;
                n_res.status   = ST_REJECTED;
                if (r_phase == PH_FRAME && r_byte_count >= LEN_W'(1)
                        && r_byte_count <= LEN_W'(FRAME_BYTES)) begin
                    n_res.tx_byte = frame_byte;
                end
            end else begin
                load_start   = 1'b1;
                n_stop       = (in_index == CMD_STOP);
                n_block_len  = (int'(in_len) > MAX_BLOCK_BYTES) ? LEN_W'(MAX_BLOCK_BYTES)
                                                                 : in_len;
                n_byte_count = '0;
                n_poll_count = '0;
                n_crc16      = '0;
                n_crc_hi     = '0;
                n_r1         = BYTE_FILL;
                n_phase      = PH_DUMMY;
            end
        end else begin
            case (r_phase)
                PH_DUMMY: begin
                    n_poll_count = '0;
                    n_phase      = PH_READY;
                end
                PH_READY: begin
                    n_poll_count = poll_inc;
                    if (in_rx == BYTE_FILL) begin
                        n_res.tx_byte = frame_byte;
                        n_byte_count  = LEN_W'(1);
                        n_phase       = PH_FRAME;
                    end else if (poll_inc >= r_ready_limit) begin
                        n_r1         = in_rx;
                        n_res.busy   = 1'b0;
                        n_res.done   = 1'b1;
                        n_res.status = ST_NOT_READY;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_FRAME: begin
                    if (r_byte_count < LEN_W'(FRAME_BYTES)) begin
                        n_res.tx_byte = frame_byte;
                        n_byte_count  = count_inc;
                    end else begin
                        n_poll_count = '0;
                        n_phase      = r_stop ? PH_STUFF : PH_R1;
                    end
                end
                PH_STUFF: begin
                    n_poll_count = '0;
                    n_phase      = PH_R1;
                end
                PH_R1: begin
                    n_poll_count = poll_inc;
                    n_r1         = in_rx;
                    if (!in_rx[7]) begin
                        if (in_rx == 8'h00 && r_block_len != '0) begin
                            n_poll_count = '0;
                            n_phase      = PH_TOKEN;
                        end else begin
                            n_res.busy = 1'b0;
                            n_res.done = 1'b1;
                            n_phase    = PH_IDLE;
                        end
                    end else if (poll_inc >= {{(POLL_W-TRIES_W){1'b0}}, r_response_tries}) begin
                        n_res.busy   = 1'b0;
                        n_res.done   = 1'b1;
                        n_res.status = ST_NO_RESPONSE;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_TOKEN: begin
                    n_poll_count = poll_inc;
                    if (in_rx == BYTE_TOKEN) begin
                        n_byte_count = '0;
                        n_crc16      = '0;
                        n_phase      = PH_DATA;
                    end else if (in_rx != BYTE_FILL || poll_inc >= r_token_limit) begin
                        n_res.busy   = 1'b0;
                        n_res.done   = 1'b1;
                        n_res.status = ST_BAD_TOKEN;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_DATA: begin
                    n_res.data_byte  = in_rx;
                    n_res.data_valid = 1'b1;
                    n_crc16          = crc16_next;
                    n_byte_count     = count_inc;
                    if (count_inc >= r_block_len) begin
                        n_phase = PH_CRCHI;
                    end
                end
                PH_CRCHI: begin
                    n_crc_hi = in_rx;
                    n_phase  = PH_CRCLO;
                end
                PH_CRCLO: begin
                    n_res.busy = 1'b0;
                    n_res.done = 1'b1;
                    if (r_crc_verify && {r_crc_hi, in_rx} != r_crc16) begin
                        n_res.status = ST_CRC_MISMATCH;
                    end
                    n_phase = PH_IDLE;
                end
                default: begin
                    // byte report while idle is ignored
                    n_res.busy = 1'b0;
                    n_phase    = PH_IDLE;
                end
            endcase
        end

        n_res.response = n_r1;
    end

    // state, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_verify     <= 1'b1;
            r_ready_limit    <= POLL_W'(500000);
            r_token_limit    <= POLL_W'(50000);
            r_response_tries <= TRIES_W'(20);
            r_phase          <= PH_IDLE;
            r_byte_count     <= '0;
            r_poll_count     <= '0;
            r_crc16          <= '0;
            r_crc_hi         <= '0;
            r_r1             <= BYTE_FILL;
            r_stop           <= 1'b0;
            r_block_len      <= '0;
            r_out_vld        <= 1'b0;
            r_skid_vld       <= 1'b0;
            r_crc_cnt        <= CRC_CNT_W'(FRAME_HELD);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_CRC_VERIFY:     r_crc_verify     <= i_cfg_data[0];
                    CFG_READY_LIMIT:    r_ready_limit    <= i_cfg_data;
                    CFG_TOKEN_LIMIT:    r_token_limit    <= i_cfg_data;
                    CFG_RESPONSE_TRIES: r_response_tries <= i_cfg_data[TRIES_W-1:0];
                    default:            r_crc_verify     <= r_crc_verify;
                endcase
            end

            if (s_accept) begin
                r_phase      <= n_phase;
                r_byte_count <= n_byte_count;
                r_poll_count <= n_poll_count;
                r_crc16      <= n_crc16;
                r_crc_hi     <= n_crc_hi;
                r_r1         <= n_r1;
                r_stop       <= n_stop;
                r_block_len  <= n_block_len;
            end

            // crc7 unit: restart on a start, then one frame byte per cycle
            if (s_accept && load_start) begin
                r_crc_cnt <= '0;
            end else if (r_crc_cnt < CRC_CNT_W'(FRAME_HELD)) begin
                r_crc_cnt <= r_crc_cnt + 1'b1;
            end

            // output register with one skid entry behind it
            if (m_take || !r_out_vld) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= s_accept;
                end
            end else if (s_accept) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // payload: frame bytes, crc7 accumulator and result data
    always_ff @(posedge i_clk) begin
        if (s_accept && load_start) begin
            r_frame[0] <= CMD_START | {2'b00, in_index};
            r_frame[1] <= in_arg[31:24];
            r_frame[2] <= in_arg[23:16];
            r_frame[3] <= in_arg[15:8];
            r_frame[4] <= in_arg[7:0];
            r_crc7     <= '0;
        end else if (r_crc_cnt < CRC_CNT_W'(FRAME_HELD)) begin
            r_crc7 <= crc7_byte(r_crc7, r_frame[r_crc_cnt]);
        end

        if (m_take || !r_out_vld) begin
            r_out <= r_skid_vld ? r_skid : n_res;
        end else if (s_accept) begin
            r_skid <= n_res;
        end
    end

    // the skid entry is only ever filled behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid without output beat");

    // the crc7 byte must be finished before the frame reaches it
    a_crc7_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FRAME && r_byte_count >= LEN_W'(FRAME_HELD))
            |-> r_crc_cnt == CRC_CNT_W'(FRAME_HELD))
        else $error("crc7 not complete when frame byte needed");

    // a finished transaction never also asks for another transfer
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.done) |-> (!r_out.busy && !r_out.data_valid))
        else $error("done result still busy or carrying data");

    // a rejected start leaves the transaction state untouched
    a_reject_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_cmd == CMD_TRANSACTION && r_phase != PH_IDLE)
            |=> ($stable(r_phase) && $stable(r_byte_count) && $stable(r_poll_count)))
        else $error("rejected start changed transaction state");

    // data bytes only pass while the block phase is running
    a_data_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && n_res.data_valid) |-> r_phase == PH_DATA)
        else $error("data byte flagged outside data phase");

endmodule

`default_nettype wire

// ----- tb/sd_txn_check_pkg.sv -----
// result checker for the spi-mode sd command engine: tracks the engine state,
// works out the result beat for every accepted input beat and compares it
// depends on sdspi_pkg for the result layout, status codes and register indexes
`timescale 1ns / 100ps

package sd_txn_check_pkg;
    import sdspi_pkg::*;

    typedef enum logic [3:0] {
        EP_IDLE,
        EP_DUMMY,
        EP_READY,
        EP_FRAME,
        EP_STUFF,
        EP_R1,
        EP_TOKEN,
        EP_DATA,
        EP_CRC_HI,
        EP_CRC_LO
    } t_engine_phase;

    // crc7 over the first five frame bytes, end bit appended
    function automatic logic [7:0] crc7_of_frame(input logic [7:0] b [6]);
        logic [6:0] c;
        logic       fb;
        c = '0;
        for (int i = 0; i < 5; i++) begin
            for (int k = 7; k >= 0; k--) begin
                fb = c[6] ^ b[i][k];
                c  = {c[5:0], 1'b0};
                if (fb) begin
                    c = c ^ 7'h09;
                end
            end
        end
        return {c, 1'b1};
    endfunction

    // crc16-ccitt, bit-serial, msb first
    function automatic logic [15:0] ccitt_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ 16'h1021;
            end
        end
        return r;
    endfunction

    class sd_txn_checker;
        // register copies
        bit           crc_verify;
        logic [19:0]  ready_limit;
        logic [19:0]  token_limit;
        logic [7:0]   response_tries;

        // engine state
        t_engine_phase phase;
        logic [7:0]   frame [6];
        int unsigned  byte_count;
        int unsigned  poll_count;
        logic [15:0]  data_crc;
        logic [15:0]  card_crc;
        logic [7:0]   r1;
        bit           stop_cmd;
        int unsigned  block_len;

        t_result      pending_results [$];
        int unsigned  results_seen;
        int unsigned  mismatches;

        function new();
            crc_verify     = 1'b1;
            ready_limit    = 20'd500000;
            token_limit    = 20'd50000;
            response_tries = 8'd20;
            phase          = EP_IDLE;
            foreach (frame[i]) frame[i] = '0;
            byte_count     = 0;
            poll_count     = 0;
            data_crc       = '0;
            card_crc       = '0;
            r1             = BYTE_FILL;
            stop_cmd       = 1'b0;
            block_len      = 0;
            results_seen   = 0;
            mismatches     = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [19:0] v);
            case (idx)
                CFG_CRC_VERIFY:     crc_verify     = v[0];
                CFG_READY_LIMIT:    ready_limit    = v;
                CFG_TOKEN_LIMIT:    token_limit    = v;
                CFG_RESPONSE_TRIES: response_tries = v[7:0];
                default: ;
            endcase
        endfunction

        // advance the engine by one accepted beat and queue its result
        function void take_beat(t_command cmd, logic [5:0] idx, logic [31:0] arg,
                                logic [9:0] len, logic [7:0] rx);
            t_result r;
            r         = '0;
            r.tx_byte = BYTE_FILL;
            r.busy    = 1'b1;
            r.status  = ST_OK;
            if (cmd == CMD_TRANSACTION) begin
                if (phase != EP_IDLE) begin
                    // start while running: state kept, pending frame byte repeated
                    r.rejected = 1'b1;
                    r.status   = ST_REJECTED;
                    if (phase == EP_FRAME && byte_count >= 1 && byte_count <= 6) begin
                        r.tx_byte = frame[byte_count - 1];
                    end
                end else begin
                    frame[0]   = CMD_START | {2'b00, idx};
                    frame[1]   = arg[31:24];
                    frame[2]   = arg[23:16];
                    frame[3]   = arg[15:8];
                    frame[4]   = arg[7:0];
                    frame[5]   = crc7_of_frame(frame);
                    stop_cmd   = (idx == CMD_STOP);
                    block_len  = (len > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : len;
                    byte_count = 0;
                    poll_count = 0;
                    data_crc   = '0;
                    card_crc   = '0;
                    r1         = BYTE_FILL;
                    phase      = EP_DUMMY;
                end
            end else begin
                case (phase)
                    EP_DUMMY: begin
                        poll_count = 0;
                        phase      = EP_READY;
                    end
                    EP_READY: begin
                        poll_count++;
                        if (rx == BYTE_FILL) begin
                            r.tx_byte  = frame[0];
                            byte_count = 1;
                            phase      = EP_FRAME;
                        end else if (poll_count >= ready_limit) begin
                            r1       = rx;
                            r.busy   = 1'b0;
                            r.done   = 1'b1;
                            r.status = ST_NOT_READY;
                            phase    = EP_IDLE;
                        end
                    end
                    EP_FRAME: begin
                        if (byte_count < 6) begin
                            r.tx_byte = frame[byte_count];
                            byte_count++;
                        end else begin
                            poll_count = 0;
                            phase      = stop_cmd ? EP_STUFF : EP_R1;
                        end
                    end
                    EP_STUFF: begin
                        poll_count = 0;
                        phase      = EP_R1;
                    end
                    EP_R1: begin
                        poll_count++;
                        r1 = rx;
                        if (!rx[7]) begin
                            if (rx == 8'h00 && block_len != 0) begin
                                poll_count = 0;
                                phase      = EP_TOKEN;
                            end else begin
                                r.busy = 1'b0;
                                r.done = 1'b1;
                                phase  = EP_IDLE;
                            end
                        end else if (poll_count >= response_tries) begin
                            r.busy   = 1'b0;
                            r.done   = 1'b1;
                            r.status = ST_NO_RESPONSE;
                            phase    = EP_IDLE;
                        end
                    end
                    EP_TOKEN: begin
                        poll_count++;
                        if (rx == BYTE_TOKEN) begin
                            byte_count = 0;
                            data_crc   = '0;
                            phase      = EP_DATA;
                        end else if (rx != BYTE_FILL || poll_count >= token_limit) begin
                            r.busy   = 1'b0;
                            r.done   = 1'b1;
                            r.status = ST_BAD_TOKEN;
                            phase    = EP_IDLE;
                        end
                    end
                    EP_DATA: begin
                        r.data_byte  = rx;
                        r.data_valid = 1'b1;
                        data_crc     = ccitt_update(data_crc, rx);
                        byte_count++;
                        if (byte_count >= block_len) begin
                            phase = EP_CRC_HI;
                        end
                    end
                    EP_CRC_HI: begin
                        card_crc = {rx, 8'h00};
                        phase    = EP_CRC_LO;
                    end
                    EP_CRC_LO: begin
                        card_crc[7:0] = rx;
                        r.busy        = 1'b0;
                        r.done        = 1'b1;
                        r.status      = (crc_verify && card_crc != data_crc) ?
                                        ST_CRC_MISMATCH : ST_OK;
                        phase         = EP_IDLE;
                    end
                    default: begin
                        // byte while idle is ignored
                        phase  = EP_IDLE;
                        r.busy = 1'b0;
                    end
                endcase
            end
            r.response = r1;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch at result %0d: %s", results_seen, msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
            end
        endtask

        // beat layout: [7:0] tx, [8] busy, [16:9] data, [17] done,
        // [20:18] status, [28:21] response, [29] rejected; tuser data_valid
        task check_result(logic [31:0] beat, logic dv);
            t_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %08h with nothing pending", beat));
                return;
            end
            want = pending_results.pop_front();
            compare_field("tx_byte",    beat[7:0],           want.tx_byte);
            compare_field("busy",       {7'd0, beat[8]},     {7'd0, want.busy});
            compare_field("data_byte",  beat[16:9],          want.data_byte);
            compare_field("data_valid", {7'd0, dv},          {7'd0, want.data_valid});
            compare_field("done",       {7'd0, beat[17]},    {7'd0, want.done});
            compare_field("status",     {5'd0, beat[20:18]}, {5'd0, want.status});
            compare_field("response",   beat[28:21],         want.response);
            compare_field("rejected",   {7'd0, beat[29]},    {7'd0, want.rejected});
        endtask

        task finish_check();
            if (pending_results.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived",
                                          pending_results.size()));
            end
        endtask
    endclass

endpackage

// ----- tb/sd_spi_command_transaction_test.sv -----
// stream-level test of the spi-mode sd command engine: a card model answers
// every transfer, each result beat is checked against sd_txn_checker
// depends on sdspi_pkg, sd_txn_check_pkg and the engine rtl
`timescale 1ns / 100ps

module sd_spi_command_transaction_test;
    import sdspi_pkg::*;
    import sd_txn_check_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;  // cycles with no beat at all
    localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off

    // how the card behaves in one transaction
    typedef struct packed {
        int unsigned ready_wait;   // busy bytes before 0xff
        int unsigned r1_wait;      // bytes with bit 7 set before r1
        logic [7:0]  r1_value;
        int unsigned token_wait;   // 0xff fill before the token
        logic [7:0]  token_value;
        logic [15:0] crc_flip;     // xor applied to the sent data crc
        int unsigned noise_pct;    // chance of a stray start per byte
    } t_card_plan;

    localparam t_card_plan CLEAN_CARD = '{
        ready_wait: 0, r1_wait: 0, r1_value: 8'h00, token_wait: 0,
        token_value: BYTE_TOKEN, crc_flip: 16'h0000, noise_pct: 0
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_CRC_VERIFY;
    logic [19:0] i_cfg_data = '0;

    sd_txn_checker chk = new();

    int unsigned beats_sent = 0;
    int unsigned idle_cycles = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;
    bit          hold_request = 1'b0;

    sd_spi_command_transaction DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // every accepted result beat goes to the checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            chk.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // watchdog: too long without any beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL sd_spi_command_transaction");
                $finish;
            end
        end
    end

    // result side: random stalls, stretches with none, one long hold-off
    initial begin
        int unsigned stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = rx_gaps_on ? $urandom_range(0, 17) : 0;
            end
            if ($urandom_range(0, 39) == 0) rx_gaps_on = !rx_gaps_on;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // one input beat; tdata = {rx_byte, data_length, cmd_argument, cmd_index}
    task automatic send_beat(t_command cmd, logic [5:0] idx, logic [31:0] arg,
                             logic [9:0] len, logic [7:0] rx);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 39) == 0) tx_gaps_on = !tx_gaps_on;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {rx, len, arg, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        chk.take_beat(cmd, idx, arg, len, rx);
        beats_sent++;
    endtask

    // leaves valid high so the next register follows without a gap
    task automatic write_one(t_cfg_reg idx, logic [19:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        chk.set_reg(idx, v);
    endtask

    task automatic write_regs(bit crc_on, logic [19:0] rdy, logic [19:0] tok,
                              logic [7:0] tries);
        write_one(CFG_CRC_VERIFY, {19'd0, crc_on});
        write_one(CFG_READY_LIMIT, rdy);
        write_one(CFG_TOKEN_LIMIT, tok);
        write_one(CFG_RESPONSE_TRIES, {12'd0, tries});
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering beats, let every result come out, then wait the extra cycles given
    task automatic settle_idle(int unsigned extra);
        i_s_axis_tvalid <= 1'b0;
        while (chk.pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // the byte the card returns, chosen from where the engine is now
    function automatic logic [7:0] card_reply(t_card_plan p);
        case (chk.phase)
            EP_READY:  return (chk.poll_count < p.ready_wait) ?
                              8'($urandom_range(0, 254)) : BYTE_FILL;
            EP_R1:     return (chk.poll_count < p.r1_wait) ?
                              8'($urandom_range(128, 255)) : p.r1_value;
            EP_TOKEN:  return (chk.poll_count < p.token_wait) ? BYTE_FILL : p.token_value;
            EP_CRC_HI: return chk.data_crc[15:8] ^ p.crc_flip[15:8];
            EP_CRC_LO: return chk.data_crc[7:0] ^ p.crc_flip[7:0];
            default:   return 8'($urandom);
        endcase
    endfunction

    // answer transfers until the engine finishes, with the odd stray start
    task automatic serve_card(t_card_plan p);
        while (chk.phase != EP_IDLE) begin
            if ($urandom_range(0, 99) < p.noise_pct) begin
                send_beat(CMD_TRANSACTION, 6'($urandom), $urandom, 10'($urandom),
                          8'($urandom));
            end else begin
                send_beat(CMD_BYTE, 6'($urandom), $urandom, 10'($urandom), card_reply(p));
            end
        end
    endtask

    task automatic run_transaction(logic [5:0] idx, logic [31:0] arg, logic [9:0] len,
                                   t_card_plan p);
        send_beat(CMD_TRANSACTION, idx, arg, len, 8'($urandom));
        serve_card(p);
    endtask

    // waits span up to the limit when it is small, so timeouts happen
    function automatic int unsigned wait_bound(int unsigned lim);
        return (lim == 0) ? 1 : ((lim < 8) ? lim : 8);
    endfunction

    function automatic t_card_plan draw_plan();
        t_card_plan p;
        p.ready_wait  = $urandom_range(0, 1) ? 0 :
                        $urandom_range(0, wait_bound(chk.ready_limit));
        p.r1_wait     = $urandom_range(0, 1) ? 0 :
                        $urandom_range(0, wait_bound(chk.response_tries));
        p.r1_value    = ($urandom_range(0, 9) < 7) ? 8'h00 : 8'($urandom_range(1, 127));
        p.token_wait  = $urandom_range(0, 1) ? 0 :
                        $urandom_range(0, wait_bound(chk.token_limit));
        p.token_value = ($urandom_range(0, 9) < 8) ? BYTE_TOKEN :
                        8'($urandom_range(0, 253));
        p.crc_flip    = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0;
        p.noise_pct   = 4;
        return p;
    endfunction

    // mostly well-formed transactions with short blocks, some stray bytes
    task automatic random_traffic(int unsigned until_beats);
        logic [5:0] idx;
        logic [9:0] len;
        while (beats_sent < until_beats) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beat(CMD_BYTE, 6'($urandom), $urandom, 10'($urandom), 8'($urandom));
            end else begin
                idx = ($urandom_range(0, 6) == 0) ? CMD_STOP : 6'($urandom);
                len = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(1, 24));
                run_transaction(idx, $urandom, len, draw_plan());
            end
        end
    endtask

    initial begin
        t_card_plan p;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // largest limits, crc check on
        write_regs(1'b1, 20'hFFFFF, 20'hFFFFF, 8'hFF);
        // byte while idle
        send_beat(CMD_BYTE, 6'h00, 32'h0, 10'd0, BYTE_FILL);
        // stop command with stuff byte, and a start while it runs
        send_beat(CMD_TRANSACTION, CMD_STOP, 32'hFFFF_FFFF, 10'd0, 8'h00);
        send_beat(CMD_TRANSACTION, 6'h3F, 32'h0, 10'h3FF, 8'hFF);
        serve_card(CLEAN_CARD);
        // highest index, one-byte block with a good crc
        run_transaction(6'h3F, 32'h0, 10'd1, CLEAN_CARD);
        random_traffic(300);

        // limits of one, crc check off
        settle_idle(5);
        write_regs(1'b0, 20'd1, 20'd1, 8'd1);
        // card never ready
        p            = CLEAN_CARD;
        p.ready_wait = 1;
        run_transaction(6'd17, 32'h1234_5678, 10'd4, p);
        // no r1
        p         = CLEAN_CARD;
        p.r1_wait = 1;
        run_transaction(6'd17, 32'h8765_4321, 10'd4, p);
        // token never comes
        p            = CLEAN_CARD;
        p.token_wait = 1;
        run_transaction(6'd18, 32'h0000_0200, 10'd8, p);
        random_traffic(550);

        // small limits, zero included
        settle_idle(5);
        write_regs(1'($urandom_range(0, 1)), 20'($urandom_range(0, 5)),
                   20'($urandom_range(0, 5)), 8'($urandom_range(0, 5)));
        random_traffic(800);

        // usual limits; an oversized block while the result side holds off
        settle_idle(5);
        write_regs(1'b1, 20'd500000, 20'd50000, 8'd20);
        hold_request = 1'b1;
        run_transaction(6'($urandom), $urandom, 10'($urandom_range(513, 1023)), CLEAN_CARD);
        random_traffic(1350);

        settle_idle(20);
        chk.finish_check();
        if (chk.mismatches == 0) begin
            $display("PASS sd_spi_command_transaction");
        end else begin
            $display("FAIL sd_spi_command_transaction");
        end
        $finish;
    end

endmodule
